// ===== hdl/ttt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants for the tick timer table.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int ID_W       = 4;
  localparam int DELAY_W    = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SCHED  = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_SCHED     = 3'd0,
    KIND_CANCEL    = 3'd1,
    KIND_EXPIRE    = 3'd2,
    KIND_IDLE_TICK = 3'd3,
    KIND_NOOP      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    func_t               func;
    logic [ID_W-1:0]     timer_id;
    logic [DELAY_W-1:0]  delay_ticks;
    logic                repeating;
  } req_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] timer_id_res;
    logic            last_of_run;
  } res_t;

  // Commands from the sequencer to the entry store
  typedef struct packed {
    idx_t               rd_addr;
    idx_t               wr_addr;
    logic               wr_target;
    logic               wr_period;
    logic               arm;
    logic               disarm;
    logic               rep_data;
    time_t              target_data;
    logic [DELAY_W-1:0] period_data;
  } store_cmd_t;

endpackage

// ===== hdl/ttt_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_alu
// Shared time unit: one wrapping adder on the current time and one equality
// compare of a stored target against the current time.
// ----------------------------------------------------------------------------
module ttt_alu (
  input  ttt_pkg::time_t now,
  input  ttt_pkg::time_t operand,
  input  ttt_pkg::time_t target,
  output ttt_pkg::time_t sum,
  output logic           equal
);
  import ttt_pkg::*;

  assign sum   = now + operand;
  assign equal = (target == now);

endmodule

// ===== hdl/ttt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_store
// Entry table: target and period memories with registered read, armed and
// repeat flags in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module ttt_store (
  input  logic                              clk,
  input  logic                              rst,
  input  ttt_pkg::store_cmd_t               cmd,
  output ttt_pkg::time_t                    rd_target,
  output logic [ttt_pkg::DELAY_W-1:0]       rd_period,
  output logic [ttt_pkg::MAX_TIMERS-1:0]    armed,
  output logic [ttt_pkg::MAX_TIMERS-1:0]    repeats
);
  import ttt_pkg::*;

  time_t              target_mem [MAX_TIMERS];
  logic [DELAY_W-1:0] period_mem [MAX_TIMERS];

  always_ff @(posedge clk) begin
    if (cmd.wr_target) begin
      target_mem[cmd.wr_addr] <= cmd.target_data;
    end
    if (cmd.wr_period) begin
      period_mem[cmd.wr_addr] <= cmd.period_data;
    end
    rd_target <= target_mem[cmd.rd_addr];
    rd_period <= period_mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= '0;
      repeats <= '0;
    end else if (cmd.arm) begin
      armed[cmd.wr_addr]   <= 1'b1;
      repeats[cmd.wr_addr] <= cmd.rep_data;
    end else if (cmd.disarm) begin
      armed[cmd.wr_addr] <= 1'b0;
    end
  end

endmodule

// ===== hdl/ttt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer: handles schedule and cancel requests, walks the table one entry
// per cycle on a tick while expiries can leave; holds current time and result.
// ----------------------------------------------------------------------------
module ttt_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  ttt_pkg::req_t                  req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output ttt_pkg::res_t                  res,
  output ttt_pkg::store_cmd_t            cmd,
  input  logic [ttt_pkg::DELAY_W-1:0]    rd_period,
  input  logic [ttt_pkg::MAX_TIMERS-1:0] armed,
  input  logic [ttt_pkg::MAX_TIMERS-1:0] repeats,
  output ttt_pkg::time_t                 now,
  output ttt_pkg::time_t                 alu_operand,
  input  ttt_pkg::time_t                 alu_sum,
  input  logic                           alu_equal
);
  import ttt_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(MAX_TIMERS - 1);

  state_t state, state_next;
  idx_t   idx, idx_next;
  idx_t   pend_id, pend_id_next;
  logic   pend_valid, pend_valid_next;
  time_t  now_next;

  logic   out_free;
  logic   acc;
  logic   id_ok;
  idx_t   req_idx;
  logic   scan_match;
  logic   scan_adv;
  logic   emit;
  res_t   emit_data;

  assign out_free   = !res_valid || !res_stall;
  assign req_stall  = (state != ST_IDLE) || !out_free;
  assign acc        = req_valid && !req_stall;
  assign id_ok      = (32'(req.timer_id) < 32'(MAX_TIMERS));
  assign req_idx    = IDX_W'(req.timer_id);
  assign scan_match = armed[idx] && alu_equal;
  // Hold the entry when a buffered expiry cannot leave yet
  assign scan_adv   = !(scan_match && pend_valid && !out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && req.func == FUNC_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_adv && idx == LAST_IDX) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    emit            = 1'b0;
    emit_data       = '0;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    idx_next        = idx;
    now_next        = now;
    alu_operand     = '0;
    unique case (state)
      ST_IDLE: begin
        alu_operand     = TIME_BITS'(req.delay_ticks);
        idx_next        = '0;
        cmd.wr_addr     = req_idx;
        cmd.target_data = alu_sum;
        cmd.period_data = req.delay_ticks;
        cmd.rep_data    = req.repeating;
        emit_data.timer_id_res = req.timer_id;
        emit_data.last_of_run  = 1'b1;
        emit_data.kind         = KIND_NOOP;
        if (acc) begin
          unique case (req.func)
            FUNC_SCHED: begin
              emit = 1'b1;
              if (id_ok) begin
                cmd.wr_target  = 1'b1;
                cmd.wr_period  = 1'b1;
                cmd.arm        = 1'b1;
                emit_data.kind = KIND_SCHED;
              end
            end
            FUNC_CANCEL: begin
              emit = 1'b1;
              if (id_ok && armed[req_idx]) begin
                cmd.disarm     = 1'b1;
                emit_data.kind = KIND_CANCEL;
              end
            end
            FUNC_TICK, FUNC_NONE: begin
              emit = 1'b0;
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_addr     = idx;
        cmd.wr_addr     = idx;
        cmd.target_data = alu_sum;
        // A repeat period of zero counts as one
        alu_operand = (rd_period == '0) ? TIME_BITS'(1) : TIME_BITS'(rd_period);
        emit_data.kind         = KIND_EXPIRE;
        emit_data.timer_id_res = ID_W'(pend_id);
        emit_data.last_of_run  = 1'b0;
        if (scan_adv) begin
          cmd.rd_addr = idx + 1'b1;
          idx_next    = idx + 1'b1;
          if (scan_match) begin
            emit            = pend_valid;
            pend_valid_next = 1'b1;
            pend_id_next    = idx;
            if (repeats[idx]) begin
              cmd.wr_target = 1'b1;
            end else begin
              cmd.disarm = 1'b1;
            end
          end
        end
      end
      ST_FIN: begin
        alu_operand           = TIME_BITS'(1);
        emit_data.last_of_run = 1'b1;
        if (pend_valid) begin
          emit_data.kind         = KIND_EXPIRE;
          emit_data.timer_id_res = ID_W'(pend_id);
        end else begin
          emit_data.kind         = KIND_IDLE_TICK;
          emit_data.timer_id_res = '0;
        end
        if (out_free) begin
          emit            = 1'b1;
          now_next        = alu_sum;
          pend_valid_next = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      now        <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
      now        <= now_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id <= pend_id_next;
    if (emit) begin
      res <= emit_data;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("request taken while a tick scan is running");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("buffered expiry left over after a tick");

  a_time_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (now == $past(now) + TIME_BITS'(1)))
    else $error("time did not advance at end of tick");

  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FIN) |=> $stable(now))
    else $error("time changed outside end of tick");

  a_scan_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && emit) |-> (pend_valid && out_free))
    else $error("expiry issued without a buffered entry or a free slot");

endmodule

// ===== hdl/tick_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_timer_table
// Table of tick-driven timers: schedule, cancel and tick requests, with one
// expiry result per matching entry in ascending entry order.
// ----------------------------------------------------------------------------
// Schedule and cancel: result registered, valid in the cycle after acceptance.
// Tick: the scan checks one entry per cycle with the shared adder/comparator,
//   except while a buffered expiry waits for the result side; the last result
//   and the time advance follow the scan, then the next request is taken.
// Reset (rst, synchronous): all entries disarmed, time back to zero, output
//   empty; a request can be taken in the first cycle after reset.
module tick_timer_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ttt_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output ttt_pkg::res_t  res
);
  import ttt_pkg::*;

  store_cmd_t             cmd;
  time_t                  rd_target;
  logic [DELAY_W-1:0]     rd_period;
  logic [MAX_TIMERS-1:0]  armed;
  logic [MAX_TIMERS-1:0]  repeats;
  time_t                  now;
  time_t                  alu_operand;
  time_t                  alu_sum;
  logic                   alu_equal;

  ttt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .cmd         (cmd),
    .rd_period   (rd_period),
    .armed       (armed),
    .repeats     (repeats),
    .now         (now),
    .alu_operand (alu_operand),
    .alu_sum     (alu_sum),
    .alu_equal   (alu_equal)
  );

  ttt_store u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_target (rd_target),
    .rd_period (rd_period),
    .armed     (armed),
    .repeats   (repeats)
  );

  ttt_alu u_alu (
    .now     (now),
    .operand (alu_operand),
    .target  (rd_target),
    .sum     (alu_sum),
    .equal   (alu_equal)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tick timer table against a cycle-free predictor of its entry
// table. A directed opening covers idle ticks, zero delays, zero periods,
// overwrites and cancels of idle entries. Random schedule/tick sequences
// with random stalls and gaps on both channels follow.
// ----------------------------------------------------------------------------
module testbench;
  import ttt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_ITEMS  = 165;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    req_t r;
    logic drain;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  pending_req_t pending_reqs[$];
  res_t         expected_results[$];
  int           outstanding = 0;
  int           queued_items = 0;
  int           issued = 0;
  int           phase = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  // Predicted timer table
  logic             timer_armed   [MAX_TIMERS];
  time_t            timer_target  [MAX_TIMERS];
  logic [DELAY_W-1:0] timer_period [MAX_TIMERS];
  logic             timer_repeats [MAX_TIMERS];
  time_t            now_ticks;

  tick_timer_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  task automatic queue_request(input func_t f, input int id,
                               input int unsigned delay, input logic rep,
                               input logic drain);
    pending_req_t p;
    p.r.func        = f;
    p.r.timer_id    = ID_W'(id);
    p.r.delay_ticks = DELAY_W'(delay);
    p.r.repeating   = rep;
    p.drain         = drain;
    pending_reqs.push_back(p);
    if (f != FUNC_NONE) queued_items++;
  endtask

  task automatic predict_results(input req_t r);
    res_t             out;
    int               last_hit;
    logic [DELAY_W-1:0] step;
    out      = '0;
    last_hit = -1;
    case (r.func)
      FUNC_TICK: begin
        for (int i = 0; i < MAX_TIMERS; i++)
          if (timer_armed[i] && timer_target[i] == now_ticks) last_hit = i;
        // expiries go out in ascending entry order
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (timer_armed[i] && timer_target[i] == now_ticks) begin
            out.kind         = KIND_EXPIRE;
            out.timer_id_res = ID_W'(i);
            out.last_of_run  = (i == last_hit);
            expected_results.push_back(out);
            if (timer_repeats[i]) begin
              step = (timer_period[i] == '0) ? DELAY_W'(1) : timer_period[i];
              timer_target[i] = time_t'(now_ticks + step);
            end else begin
              timer_armed[i] = 1'b0;
            end
          end
        end
        if (last_hit < 0) begin
          out.kind         = KIND_IDLE_TICK;
          out.timer_id_res = '0;
          out.last_of_run  = 1'b1;
          expected_results.push_back(out);
        end
        now_ticks = now_ticks + 1'b1;
      end
      FUNC_SCHED: begin
        out.timer_id_res = r.timer_id;
        out.last_of_run  = 1'b1;
        if (r.timer_id >= MAX_TIMERS) begin
          out.kind = KIND_NOOP;
        end else begin
          timer_armed[r.timer_id]   = 1'b1;
          timer_target[r.timer_id]  = time_t'(now_ticks + r.delay_ticks);
          timer_period[r.timer_id]  = r.delay_ticks;
          timer_repeats[r.timer_id] = r.repeating;
          out.kind = KIND_SCHED;
        end
        expected_results.push_back(out);
      end
      FUNC_CANCEL: begin
        out.timer_id_res = r.timer_id;
        out.last_of_run  = 1'b1;
        if (r.timer_id >= MAX_TIMERS || !timer_armed[r.timer_id]) begin
          out.kind = KIND_NOOP;
        end else begin
          timer_armed[r.timer_id] = 1'b0;
          out.kind = KIND_CANCEL;
        end
        expected_results.push_back(out);
      end
      default: ;
    endcase
  endtask

  // Request driver: hold a stalled request, otherwise advance or idle
  always @(posedge clk) begin : drive
    pending_req_t next_item;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
      end else if (pending_reqs[0].drain && (req_valid || outstanding != 0)) begin
        // hold off until every result so far has come back
        req_valid <= 1'b0;
      end else if ($urandom_range(0, 99) <
                   ((phase == 1) ? 46 : (phase == 3) ? 6 : 0)) begin
        req_valid <= 1'b0;
      end else begin
        next_item = pending_reqs.pop_front();
        req       <= next_item.r;
        req_valid <= 1'b1;
        issued    <= issued + 1;
      end
    end
    phase <= (issued / 25) % 4;
  end

  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(0, 99) <
                       ((phase == 2) ? 46 : (phase == 3) ? 6 : 0));
  end

  // Result monitor: check first, then predict the request taken at this edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        timer_armed[i]   = 1'b0;
        timer_target[i]  = '0;
        timer_period[i]  = '0;
        timer_repeats[i] = 1'b0;
      end
      now_ticks = '0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d id %0d last %0d",
                     res.kind, res.timer_id_res, res.last_of_run);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind || res.timer_id_res !== want.timer_id_res ||
              res.last_of_run !== want.last_of_run) begin
            if (mismatches < 10)
              $display({"mismatch: expected kind %0d id %0d last %0d, ",
                        "got kind %0d id %0d last %0d"},
                       want.kind, want.timer_id_res, want.last_of_run,
                       res.kind, res.timer_id_res, res.last_of_run);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) predict_results(req);
    end
    outstanding <= expected_results.size();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[tick_timer_table] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int               pick;
    int               cnt;
    int               ticks;
    logic [DELAY_W-1:0] delay;
    logic             rep;
    logic             full;

    // Directed opening
    queue_request(FUNC_TICK,   0,  0, 1'b0, 1'b0); // tick with nothing armed
    queue_request(FUNC_CANCEL, 5,  0, 1'b0, 1'b0); // cancel of idle entry
    queue_request(FUNC_SCHED,  0,  0, 1'b0, 1'b0); // zero delay, one-shot
    queue_request(FUNC_SCHED,  15, 0, 1'b1, 1'b0); // repeating with zero period
    queue_request(FUNC_SCHED,  7,  2, 1'b1, 1'b0);
    queue_request(FUNC_SCHED,  1,  3, 1'b0, 1'b0);
    queue_request(FUNC_SCHED,  1,  1, 1'b0, 1'b0); // overwrite armed entry
    queue_request(FUNC_SCHED,  9,  32'hFFFF_FFFF, 1'b1, 1'b0); // target wraps
    queue_request(FUNC_SCHED,  12, 32'hAAAA_5555, 1'b0, 1'b0);
    queue_request(FUNC_NONE,   6,  32'h1234_5678, 1'b1, 1'b0); // ignored code
    repeat (5) queue_request(FUNC_TICK, 0, 0, 1'b0, 1'b0);
    queue_request(FUNC_CANCEL, 15, 0, 1'b0, 1'b1);
    queue_request(FUNC_CANCEL, 15, 0, 1'b0, 1'b0);
    queue_request(FUNC_CANCEL, 9,  0, 1'b0, 1'b0);
    queue_request(FUNC_SCHED,  4,  32'h5555_AAAA, 1'b1, 1'b0);
    queue_request(FUNC_CANCEL, 4,  0, 1'b0, 1'b0);
    queue_request(FUNC_TICK,   0,  0, 1'b0, 1'b0);

    // Random part: mostly schedule-then-tick runs, some bursts, some noise
    while (queued_items < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt)
          queue_request(FUNC_SCHED, $urandom_range(0, 15), $urandom_range(0, 5),
                        1'($urandom_range(0, 1)), ($urandom_range(0, 49) == 0));
        if ($urandom_range(0, 9) < 4)
          queue_request(FUNC_CANCEL, $urandom_range(0, 15), $urandom, 1'b0, 1'b0);
        ticks = $urandom_range(1, 6);
        repeat (ticks) queue_request(FUNC_TICK, $urandom_range(0, 15), $urandom,
                                     1'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 70) begin
        // many entries sharing one target, all of them now and then
        delay = $urandom_range(0, 3);
        rep   = 1'($urandom_range(0, 1));
        full  = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < MAX_TIMERS; i++)
          if (full || $urandom_range(0, 3) != 0)
            queue_request(FUNC_SCHED, i, delay, rep, 1'b0);
        repeat (delay + 2) queue_request(FUNC_TICK, 0, 0, 1'b0, 1'b0);
      end else begin
        cnt = $urandom_range(1, 3);
        repeat (cnt)
          queue_request(func_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom,
                        1'($urandom_range(0, 1)), ($urandom_range(0, 49) == 0));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[tick_timer_table] OK");
    end else begin
      $display("[tick_timer_table] ERROR");
    end
    $finish;
  end

endmodule
